### hw/rtl/delta_chunk_frame_blitter_defines.svh
// Assertion macros for the delta chunk frame blitter.
// Used by delta_chunk_frame_blitter.sv; needs no other file.
`ifndef DELTA_CHUNK_FRAME_BLITTER_DEFINES_SVH
`define DELTA_CHUNK_FRAME_BLITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define DCFB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DCFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DCFB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define DCFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/dcfb_pkg.sv
// Types and constants for the delta chunk frame blitter.
// No dependencies; imported by dcfb_parser and delta_chunk_frame_blitter.
package dcfb_pkg;

  localparam logic [8:0] ROW_MAX = 9'd511;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [7:0] color;
    logic       frame_done;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_HDR2   = 3'd2,
    PH_HDR3   = 3'd3,
    PH_HDR4   = 3'd4,
    PH_HDR5   = 3'd5,
    PH_PIXELS = 3'd6,
    PH_IDLE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

endpackage

### hw/rtl/delta_chunk_frame_blitter.sv
// Top level of the delta chunk frame blitter: parser plus output register and skid.
// Depends on dcfb_pkg, dcfb_parser and delta_chunk_frame_blitter_defines.svh.
//
// Takes one byte of a frame's chunk list per cycle while data_stall is low and gives
// a plot word for each pixel byte and a done word for the terminating zero option word.
// Each result is registered into the output register, or into the skid word while
// the output word waits. The output register is backed by one skid word, so bytes
// keep flowing while a result waits; data_stall rises only while the skid word is
// occupied. The start column and row are split from the chunk offset by a
// registered reciprocal multiply, which fits in the two length bytes of the header.
`include "delta_chunk_frame_blitter_defines.svh"

module delta_chunk_frame_blitter #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  dcfb_pkg::in_word_t  data,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output dcfb_pkg::out_word_t pixel
);
  import dcfb_pkg::*;

  logic      accept;
  logic      take;
  result_t   result;
  logic      skid_valid;
  out_word_t skid;

  assign data_stall = skid_valid;
  assign accept     = data_valid && !data_stall;
  assign take       = pixel_valid && !pixel_stall;

  dcfb_parser #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .word  (data),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!pixel_valid || take) begin
      if (skid_valid) begin
        pixel_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        pixel_valid <= accept && result.valid;
      end
    end else if (accept && result.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_valid || take) begin
      pixel <= skid_valid ? skid : result.word;
    end else if (accept && result.valid) begin
      skid <= result.word;
    end
  end

  `DCFB_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, pixel_valid, "skid word without output word")
  `DCFB_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && take, !skid_valid, "skid word not drained")
  `DCFB_ASSERT_IMPL(a_done_clean, clk, rst, pixel_valid && pixel.frame_done, pixel.pixel_x == 9'd0 && pixel.pixel_y == 9'd0 && pixel.color == 8'd0, "done word carries pixel data")
  `DCFB_ASSERT_IMPL(a_x_in_row, clk, rst, pixel_valid && !pixel.frame_done, 32'(pixel.pixel_x) < SCREEN_WIDTH, "column beyond screen width")

endmodule

### hw/rtl/dcfb_parser.sv
// Chunk list parser: header decode, start point split and cursor update.
// Depends on dcfb_pkg; instantiated by delta_chunk_frame_blitter.
module dcfb_parser #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  dcfb_pkg::in_word_t word,
  output dcfb_pkg::result_t  result
);
  import dcfb_pkg::*;

  localparam int         SHIFT   = 16 + $clog2(SCREEN_WIDTH);
  localparam logic [16:0] RECIP  =
    17'(((64'(1) << SHIFT) + 64'(SCREEN_WIDTH) - 64'(1)) / 64'(SCREEN_WIDTH));
  localparam logic [8:0] WIDTH_W = 9'(SCREEN_WIDTH);

  phase_t      phase;
  phase_t      phase_eff;
  phase_t      phase_next;
  logic [7:0]  option_low_byte;
  logic [15:0] chunk_offset;
  logic [15:0] bytes_left;
  logic [8:0]  cursor_x;
  logic [8:0]  cursor_y;
  logic [15:0] quot;

  logic [32:0] scaled;
  logic [24:0] back;
  logic [15:0] rem;
  logic [8:0]  x_inc;
  logic [15:0] length_word;

  // start point split: quotient registered, remainder combinational from it
  assign scaled      = 33'(chunk_offset) * 33'(RECIP);
  assign back        = 25'(quot) * 25'(WIDTH_W);
  assign rem         = chunk_offset - back[15:0];
  assign x_inc       = cursor_x + 9'd1;
  assign length_word = {word.data_byte, bytes_left[7:0]};
  assign phase_eff   = word.frame_start ? PH_HDR0 : phase;

  always_ff @(posedge clk) begin
    quot <= 16'(scaled >> SHIFT);
  end

  always_comb begin
    phase_next = phase_eff;
    case (phase_eff)
      PH_HDR0:   phase_next = PH_HDR1;
      PH_HDR1:   phase_next = ((option_low_byte | word.data_byte) == 8'd0) ? PH_IDLE : PH_HDR2;
      PH_HDR2:   phase_next = PH_HDR3;
      PH_HDR3:   phase_next = PH_HDR4;
      PH_HDR4:   phase_next = PH_HDR5;
      PH_HDR5:   phase_next = (length_word == 16'd0) ? PH_HDR0 : PH_PIXELS;
      PH_PIXELS: phase_next = (bytes_left == 16'd1) ? PH_HDR0 : PH_PIXELS;
      PH_IDLE:   phase_next = PH_IDLE;
      default:   phase_next = PH_HDR0;
    endcase
  end

  always_comb begin
    result = '0;
    case (phase_eff)
      PH_HDR1: begin
        result.valid           = ((option_low_byte | word.data_byte) == 8'd0);
        result.word.frame_done = 1'b1;
      end
      PH_PIXELS: begin
        result.valid        = 1'b1;
        result.word.pixel_x = cursor_x;
        result.word.pixel_y = cursor_y;
        result.word.color   = word.data_byte;
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      option_low_byte <= '0;
      chunk_offset    <= '0;
      bytes_left      <= '0;
      cursor_x        <= '0;
      cursor_y        <= '0;
    end else if (accept) begin
      phase <= phase_next;
      case (phase_eff)
        PH_HDR0: option_low_byte <= word.data_byte;
        PH_HDR2: chunk_offset    <= {8'd0, word.data_byte};
        PH_HDR3: chunk_offset    <= {word.data_byte, chunk_offset[7:0]};
        PH_HDR4: bytes_left      <= {8'd0, word.data_byte};
        PH_HDR5: begin
          bytes_left <= length_word;
          cursor_x   <= rem[8:0];
          cursor_y   <= (quot > 16'(ROW_MAX)) ? ROW_MAX : quot[8:0];
        end
        PH_PIXELS: begin
          bytes_left <= bytes_left - 16'd1;
          if (x_inc >= WIDTH_W) begin
            cursor_x <= '0;
            if (cursor_y != ROW_MAX) begin
              cursor_y <= cursor_y + 9'd1;
            end
          end else begin
            cursor_x <= x_inc;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for delta_chunk_frame_blitter: random and directed chunk lists.
// Depends on dcfb_pkg and the blitter RTL; predicts plot and done words in the bench itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcfb_pkg::*;

  localparam int SCREEN_W      = 320;
  localparam int RANDOM_ITEMS  = 750;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      data_valid = 1'b0;
  logic      data_stall;
  in_word_t  data = '0;
  logic      pixel_valid;
  logic      pixel_stall = 1'b0;
  out_word_t pixel;

  delta_chunk_frame_blitter #(
    .SCREEN_WIDTH(SCREEN_W)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel)
  );

  always #1 clk = ~clk;

  in_word_t  byte_q[$];
  in_word_t  frame_buf[$];
  out_word_t plot_q[$];

  // chunk parser mirror
  phase_t      parse_ph = PH_HDR0;
  logic [7:0]  opt_lo   = '0;
  logic [15:0] chunk_offs = '0;
  logic [15:0] left     = '0;
  logic [8:0]  cur_x    = '0;
  logic [8:0]  cur_y    = '0;

  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int send_run    = 0;
  bit send_quiet  = 1'b0;
  int stall_left  = 0;
  int recv_run    = 0;
  bit recv_quiet  = 1'b0;

  function automatic int pick_wait(inout int run_left, inout bit quiet);
    int n;
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      quiet = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    n = (quiet || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 13);
    return n;
  endfunction

  task automatic predict_byte(input in_word_t w);
    out_word_t r;
    int row;
    r = '0;
    if (w.frame_start) parse_ph = PH_HDR0;
    case (parse_ph)
      PH_HDR0: begin
        opt_lo = w.data_byte;
        parse_ph = PH_HDR1;
      end
      PH_HDR1: begin
        if ((opt_lo | w.data_byte) == 8'd0) begin
          r.frame_done = 1'b1;
          plot_q.push_back(r);
          parse_ph = PH_IDLE;
        end else begin
          parse_ph = PH_HDR2;
        end
      end
      PH_HDR2: begin
        chunk_offs = {8'd0, w.data_byte};
        parse_ph = PH_HDR3;
      end
      PH_HDR3: begin
        chunk_offs[15:8] = w.data_byte;
        parse_ph = PH_HDR4;
      end
      PH_HDR4: begin
        left = {8'd0, w.data_byte};
        parse_ph = PH_HDR5;
      end
      PH_HDR5: begin
        left[15:8] = w.data_byte;
        cur_x = 9'(int'(chunk_offs) % SCREEN_W);
        row = int'(chunk_offs) / SCREEN_W;
        cur_y = (row > int'(ROW_MAX)) ? ROW_MAX : 9'(row);
        parse_ph = (left == 16'd0) ? PH_HDR0 : PH_PIXELS;
      end
      PH_PIXELS: begin
        r.pixel_x = cur_x;
        r.pixel_y = cur_y;
        r.color   = w.data_byte;
        plot_q.push_back(r);
        cur_x = cur_x + 9'd1;
        if (int'(cur_x) >= SCREEN_W) begin
          cur_x = '0;
          if (cur_y < ROW_MAX) cur_y = cur_y + 9'd1;
        end
        left = left - 16'd1;
        if (left == 16'd0) parse_ph = PH_HDR0;
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (data_valid && !data_stall) predict_byte(data);
      if (!data_valid || !data_stall) begin
        if (gap_left != 0) begin
          data_valid <= 1'b0;
          gap_left--;
        end else if (byte_q.size() != 0) begin
          data <= byte_q.pop_front();
          data_valid <= 1'b1;
          gap_left = pick_wait(send_run, send_quiet);
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      pixel_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (plot_q.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d color=%0d done=%0d", $time,
                   pixel.pixel_x, pixel.pixel_y, pixel.color, pixel.frame_done);
          errors++;
        end else begin
          want = plot_q.pop_front();
          if (pixel.pixel_x !== want.pixel_x || pixel.pixel_y !== want.pixel_y ||
              pixel.color !== want.color || pixel.frame_done !== want.frame_done) begin
            $display("%0t: mismatch expected x=%0d y=%0d color=%0d done=%0d, actual x=%0d y=%0d color=%0d done=%0d",
                     $time, want.pixel_x, want.pixel_y, want.color, want.frame_done,
                     pixel.pixel_x, pixel.pixel_y, pixel.color, pixel.frame_done);
            errors++;
          end
        end
        stall_left = pick_wait(recv_run, recv_quiet);
      end
      if (stall_left != 0) begin
        pixel_stall <= 1'b1;
        stall_left--;
      end else begin
        pixel_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic fs);
    in_word_t w;
    w.data_byte   = b;
    w.frame_start = fs;
    frame_buf.push_back(w);
  endtask

  task automatic put_word16(input logic [15:0] v, input logic fs);
    put_byte(v[7:0], fs);
    put_byte(v[15:8], 1'b0);
  endtask

  task automatic put_header(input logic [15:0] opt, input logic [15:0] offs,
                            input logic [15:0] len, input logic fs);
    put_word16(opt, fs);
    put_word16(offs, 1'b0);
    put_word16(len, 1'b0);
  endtask

  task automatic flush_frame(input int keep);
    for (int i = 0; i < keep; i++) byte_q.push_back(frame_buf[i]);
    frame_buf.delete();
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || data_valid || plot_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int n_items;
    int kind;
    int n_chunks;
    int len;
    int offs;

    // last column wrap, then extremes of the pixel byte
    put_header(16'hFFFF, 16'd319, 16'd2, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    // empty chunk at the highest offset, option with only the high byte set
    put_header(16'h8000, 16'hFFFF, 16'h0000, 1'b0);
    put_word16(16'h0000, 1'b0);
    // ignored after the terminator
    put_byte(8'h5A, 1'b0);
    // restart inside a header
    put_word16(16'h0001, 1'b1);
    put_word16(16'h0140, 1'b0);
    put_word16(16'h0000, 1'b1);
    flush_frame(frame_buf.size());

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // hold off until the directed words are all back
    wait_drained();

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)),
                                               $urandom_range(0, 3) == 0);
        n_items += frame_buf.size();
        flush_frame(frame_buf.size());
      end else begin
        n_chunks = $urandom_range(0, 4);
        for (int i = 0; i < n_chunks; i++) begin
          len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 400) :
                                               $urandom_range(0, 12);
          offs = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) :
                                               $urandom_range(0, 2 * SCREEN_W);
          put_header(16'($urandom_range(1, 65535)), 16'(offs), 16'(len), i == 0);
          repeat (len) put_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        put_word16(16'h0000, n_chunks == 0);
        n_items += frame_buf.size();
        // cut the frame short now and then
        if (kind == 1) flush_frame($urandom_range(1, frame_buf.size()));
        else flush_frame(frame_buf.size());
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
        flush_frame(frame_buf.size());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
